[design/vr_pkg.sv]
// Shared types, constants and width helpers for the vector refraction pipeline.
// No dependencies; every other design file imports this package.
package vr_pkg;

  localparam int COMP_W     = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int SQRT_STEPS = 4;   // root bits resolved per sqrt stage
  localparam int D_W        = 34;  // dot product width
  localparam int EE_W       = 33;  // eta squared, signed view
  localparam int LP_W       = 33;  // eta times light component

  // register index, taken from paddr above the byte offset
  localparam logic [CFG_ADDR_W-3:0] REG_RATIO = 1'b0;

  typedef logic [COMP_W-1:0] comp_t;
  typedef comp_t [2:0]       vec3_t;

  function automatic int vr_max(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int vr_dq_w(input int f);
    return D_W - f + 1;
  endfunction

  function automatic int vr_o2_w(input int f);
    return vr_max(2 * vr_dq_w(f), 2 * f + 2) + 1;
  endfunction

  function automatic int vr_omd_w(input int f);
    return vr_o2_w(f) - f + 1;
  endfunction

  function automatic int vr_e2_w(input int f);
    return EE_W - f + 1;
  endfunction

  function automatic int vr_p_w(input int f);
    return vr_e2_w(f) + vr_omd_w(f);
  endfunction

  function automatic int vr_k_w(input int f);
    return (vr_p_w(f) >= 63) ? 64 : vr_max(vr_p_w(f), 2 * f + 2) + 1;
  endfunction

  function automatic int vr_s_w(input int f);
    return vr_k_w(f) >> 1;
  endfunction

  function automatic int vr_ed_w(input int f);
    return COMP_W + 1 + vr_dq_w(f);
  endfunction

  function automatic int vr_t_w(input int f);
    return vr_max(vr_ed_w(f), vr_s_w(f) + f + 1) + 1;
  endfunction

  function automatic int vr_tq_w(input int f);
    return vr_t_w(f) - f + 1;
  endfunction

  function automatic int vr_np_w(input int f);
    return COMP_W + vr_tq_w(f);
  endfunction

  function automatic int vr_v_w(input int f);
    return vr_max(vr_np_w(f), LP_W) + 1;
  endfunction

  function automatic int vr_vq_w(input int f);
    return vr_v_w(f) - f + 1;
  endfunction

endpackage

[design/vector_refraction.sv]
// Top level of the vector refraction pipeline (refract(I, N, eta) in fixed point).
// Depends on vr_pkg, vr_cfg, vr_front, vr_sqrt and vr_back.
//
//   port group   direction  word contents
//   s_*          in         light x/y/z, normal x/y/z, signed Q2.14 each
//   m_*          out        refracted x/y/z, signed Q2.14; tuser: tir, saturated
//   APB          in/out     register 0: refraction_ratio, unsigned Q2.14
//
// One word enters and one leaves per cycle while m_tready is high. The stages are
// six front stages, the square root at four bits a stage over the root width S
// (25 at FRAC_BITS = 14), and three back stages.
// Reset clears every valid bit and loads the ratio with 1.0.
// A stall holds the output word; earlier stages keep filling bubbles, then hold.
module vector_refraction
  import vr_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // light_x, light_y, light_z, normal_x, normal_y, normal_z
  input  logic [95:0]           s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x, out_y, out_z
  output logic [47:0]           m_tdata,
  // total_internal, saturated
  output logic [1:0]            m_tuser
);

  localparam int ED_W   = vr_ed_w(FRAC_BITS);
  localparam int K_W    = vr_k_w(FRAC_BITS);
  localparam int S_W    = vr_s_w(FRAC_BITS);
  localparam int SIDE_W = 1 + ED_W + 6 * COMP_W;

  logic [15:0] ratio;

  logic                   f_valid, f_ready, f_tir;
  vec3_t                  f_light, f_normal;
  logic signed [ED_W-1:0] f_ed;
  logic [K_W-1:0]         f_k;

  logic                   q_valid, q_ready;
  logic [S_W-1:0]         q_root;
  logic [SIDE_W-1:0]      q_side;

  vec3_t                  o_vec;
  logic                   o_tir, o_sat;

  vr_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ratio   (ratio)
  );

  vr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .ratio      (ratio),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .light      (s_tdata[47:0]),
    .normal     (s_tdata[95:48]),
    .out_valid  (f_valid),
    .out_ready  (f_ready),
    .out_light  (f_light),
    .out_normal (f_normal),
    .out_ed     (f_ed),
    .out_k      (f_k),
    .out_tir    (f_tir)
  );

  // k is non-negative whenever the root is used
  vr_sqrt #(.S_W(S_W), .SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .rad       ((2 * S_W)'(f_k[K_W-2:0])),
    .in_side   ({f_tir, f_ed, f_normal, f_light}),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .root      (q_root),
    .out_side  (q_side)
  );

  vr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .ratio     (ratio),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .root      (q_root),
    .ed        (q_side[SIDE_W-2 -: ED_W]),
    .tir       (q_side[SIDE_W-1]),
    .light     (q_side[47:0]),
    .normal    (q_side[95:48]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_vec   (o_vec),
    .out_tir   (o_tir),
    .out_sat   (o_sat)
  );

  assign m_tdata = o_vec;
  assign m_tuser = {o_sat, o_tir};

endmodule

[design/vr_cfg.sv]
// APB register file holding the refraction ratio.
// Depends on vr_pkg for the address width and register index.
module vr_cfg
  import vr_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [15:0]           ratio
);

  localparam logic [15:0] RATIO_RESET = 16'(64'd1 << FRAC_BITS);

  logic [CFG_ADDR_W-3:0] idx;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;

  always_comb begin
    unique case (idx)
      REG_RATIO: prdata = {16'd0, ratio};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio <= RATIO_RESET;
    end else if (psel && penable && pwrite && pready && idx == REG_RATIO) begin
      ratio <= pwdata[15:0];
    end
  end

endmodule

[design/vr_front.sv]
// Front pipeline: dot product, 1 - d^2, eta^2 scaling and k with the TIR test.
// Six register stages; depends on vr_pkg for vector types and width helpers.
module vr_front
  import vr_pkg::*;
#(
  parameter  int FRAC_BITS = 14,
  localparam int ED_W      = vr_ed_w(FRAC_BITS),
  localparam int K_W       = vr_k_w(FRAC_BITS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [15:0]            ratio,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vec3_t                  light,
  input  vec3_t                  normal,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vec3_t                  out_light,
  output vec3_t                  out_normal,
  output logic signed [ED_W-1:0] out_ed,
  output logic [K_W-1:0]         out_k,
  output logic                   out_tir
);

  localparam int NST   = 6;
  localparam int DQ_W  = vr_dq_w(FRAC_BITS);
  localparam int SQ_W  = 2 * DQ_W;
  localparam int O2_W  = vr_o2_w(FRAC_BITS);
  localparam int OMD_W = vr_omd_w(FRAC_BITS);
  localparam int E2_W  = vr_e2_w(FRAC_BITS);
  localparam int P_W   = vr_p_w(FRAC_BITS);
  localparam int PX_W  = vr_max(P_W, 64);
  localparam int HALF  = 1 << (FRAC_BITS - 1);

  localparam logic signed [O2_W-1:0] ONE2    = O2_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [PX_W-1:0] ONE2_X  = PX_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [PX_W-1:0] LIM     = PX_W'(1) << 62;
  localparam logic signed [PX_W-1:0] NEG_LIM = -LIM;

  logic [NST-1:0] vld, en;

  // stage registers
  logic signed [31:0]     pr1 [3];
  logic [31:0]            ee1;
  vec3_t                  li1, nv1;
  logic signed [DQ_W-1:0] dq2;
  logic signed [E2_W-1:0] e2_2;
  vec3_t                  li2, nv2;
  logic signed [SQ_W-1:0] sq3;
  logic signed [ED_W-1:0] ed3;
  logic signed [E2_W-1:0] e2_3;
  vec3_t                  li3, nv3;
  logic signed [OMD_W-1:0] omd4;
  logic signed [ED_W-1:0] ed4;
  logic signed [E2_W-1:0] e2_4;
  vec3_t                  li4, nv4;
  logic signed [P_W-1:0]  p5;
  logic signed [ED_W-1:0] ed5;
  vec3_t                  li5, nv5;

  // stage logic
  logic signed [D_W-1:0]  d;
  logic [D_W:0]           d_r;
  logic [32:0]            ee_r;
  logic signed [O2_W-1:0] o2;
  logic [O2_W:0]          o2_r;
  logic signed [PX_W-1:0] p_x, p_c, k_x;

  // a stage advances when empty or when the one after it moves
  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // round to nearest, ties away from zero: add half, less one when negative
  assign d    = D_W'(pr1[0]) + D_W'(pr1[1]) + D_W'(pr1[2]);
  assign d_r  = {d[D_W-1], d} + (D_W+1)'(HALF) - (D_W+1)'(d[D_W-1]);
  assign ee_r = {1'b0, ee1} + 33'(HALF);
  assign o2   = ONE2 - O2_W'(sq3);
  assign o2_r = {o2[O2_W-1], o2} + (O2_W+1)'(HALF) - (O2_W+1)'(o2[O2_W-1]);

  // clamp the product magnitude at 2^62 before forming k
  always_comb begin
    p_x = PX_W'(p5);
    if (p_x > LIM) begin
      p_c = LIM;
    end else if (p_x < NEG_LIM) begin
      p_c = NEG_LIM;
    end else begin
      p_c = p_x;
    end
    k_x = ONE2_X - p_c;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 3; c++) begin
        pr1[c] <= $signed(light[c]) * $signed(normal[c]);
      end
      ee1 <= ratio * ratio;
      li1 <= light;
      nv1 <= normal;
    end
    if (en[1]) begin
      dq2  <= d_r[D_W:FRAC_BITS];
      e2_2 <= E2_W'(ee_r[32:FRAC_BITS]);
      li2  <= li1;
      nv2  <= nv1;
    end
    if (en[2]) begin
      sq3  <= dq2 * dq2;
      ed3  <= $signed({1'b0, ratio}) * dq2;
      e2_3 <= e2_2;
      li3  <= li2;
      nv3  <= nv2;
    end
    if (en[3]) begin
      omd4 <= o2_r[O2_W:FRAC_BITS];
      ed4  <= ed3;
      e2_4 <= e2_3;
      li4  <= li3;
      nv4  <= nv3;
    end
    if (en[4]) begin
      p5  <= e2_4 * omd4;
      ed5 <= ed4;
      li5 <= li4;
      nv5 <= nv4;
    end
    if (en[5]) begin
      out_k      <= k_x[K_W-1:0];
      out_tir    <= k_x[PX_W-1];
      out_ed     <= ed5;
      out_light  <= li5;
      out_normal <= nv5;
    end
  end

endmodule

[design/vr_sqrt.sv]
// Pipelined integer square root, a few root bits per stage, with side payload.
// Depends on vr_pkg for the number of steps per stage.
module vr_sqrt
  import vr_pkg::*;
#(
  parameter int S_W    = 25,
  parameter int SIDE_W = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2*S_W-1:0]   rad,
  input  logic [SIDE_W-1:0]  in_side,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [S_W-1:0]     root,
  output logic [SIDE_W-1:0]  out_side
);

  localparam int RAD_W = 2 * S_W;
  localparam int ST_W  = RAD_W + S_W + 1 + S_W;
  localparam int NSTG  = (S_W + SQRT_STEPS - 1) / SQRT_STEPS;

  logic [NSTG-1:0]   vld, en;
  logic [ST_W-1:0]   st_q   [NSTG];
  logic [ST_W-1:0]   st_nx  [NSTG];
  logic [SIDE_W-1:0] side_q [NSTG];
  logic [ST_W-1:0]   first_st;

  // state word: remaining radicand bits, partial remainder, partial root
  function automatic logic [ST_W-1:0] sq_steps(input logic [ST_W-1:0] st,
                                               input int first);
    logic [RAD_W-1:0] r;
    logic [S_W:0]     rm;
    logic [S_W-1:0]   rt;
    logic [S_W+2:0]   cand, trial, diff;
    {r, rm, rt} = st;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      if (first + i < S_W) begin
        cand  = {rm, r[RAD_W-1 -: 2]};
        trial = {1'b0, rt, 2'b01};
        diff  = cand - trial;
        r     = r << 2;
        if (cand >= trial) begin
          rm = diff[S_W:0];
          rt = {rt[S_W-2:0], 1'b1};
        end else begin
          rm = cand[S_W:0];
          rt = {rt[S_W-2:0], 1'b0};
        end
      end
    end
    return {r, rm, rt};
  endfunction

  assign first_st = {rad, {(S_W + 1){1'b0}}, {S_W{1'b0}}};

  always_comb begin
    st_nx[0] = sq_steps(first_st, 0);
    for (int g = 1; g < NSTG; g++) begin
      st_nx[g] = sq_steps(st_q[g-1], g * SQRT_STEPS);
    end
  end

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int g = NSTG - 2; g >= 0; g--) begin
      en[g] = !vld[g] || en[g+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];
  assign root      = st_q[NSTG-1][S_W-1:0];
  assign out_side  = side_q[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int g = 1; g < NSTG; g++) begin
        if (en[g]) vld[g] <= vld[g-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side_q[0] <= in_side;
    for (int g = 1; g < NSTG; g++) begin
      if (en[g]) side_q[g] <= side_q[g-1];
    end
    for (int g = 0; g < NSTG; g++) begin
      if (en[g]) st_q[g] <= st_nx[g];
    end
  end

endmodule

[design/vr_back.sv]
// Back pipeline: t = eta*d + sqrt(k), then eta*I - N*t, rounding and clamping.
// Three register stages, the last is the output register; depends on vr_pkg.
module vr_back
  import vr_pkg::*;
#(
  parameter  int FRAC_BITS = 14,
  localparam int ED_W      = vr_ed_w(FRAC_BITS),
  localparam int S_W       = vr_s_w(FRAC_BITS)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [15:0]            ratio,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [S_W-1:0]         root,
  input  logic signed [ED_W-1:0] ed,
  input  logic                   tir,
  input  vec3_t                  light,
  input  vec3_t                  normal,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vec3_t                  out_vec,
  output logic                   out_tir,
  output logic                   out_sat
);

  localparam int NST  = 3;
  localparam int T_W  = vr_t_w(FRAC_BITS);
  localparam int TQ_W = vr_tq_w(FRAC_BITS);
  localparam int NP_W = vr_np_w(FRAC_BITS);
  localparam int V_W  = vr_v_w(FRAC_BITS);
  localparam int VQ_W = vr_vq_w(FRAC_BITS);
  localparam int HALF = 1 << (FRAC_BITS - 1);

  localparam logic signed [VQ_W-1:0] VMAX = VQ_W'(32767);
  localparam logic signed [VQ_W-1:0] VMIN = VQ_W'(-32768);

  logic [NST-1:0] vld, en;

  logic signed [TQ_W-1:0] tq1;
  vec3_t                  li1, nv1;
  logic                   tir1;
  logic signed [LP_W-1:0] lp2 [3];
  logic signed [NP_W-1:0] np2 [3];
  logic                   tir2;

  logic signed [T_W-1:0]  t;
  logic [T_W:0]           t_r;
  logic signed [V_W-1:0]  diff [3];
  logic [V_W:0]           rnd  [3];
  logic signed [VQ_W-1:0] vq   [3];
  vec3_t                  res;
  logic                   sat_any;

  always_comb begin
    en[NST-1] = !vld[NST-1] || out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign t   = T_W'(ed) + (T_W'(root) << FRAC_BITS);
  assign t_r = {t[T_W-1], t} + (T_W+1)'(HALF) - (T_W+1)'(t[T_W-1]);

  // round each component, then clamp to the 16-bit range
  always_comb begin
    sat_any = 1'b0;
    for (int c = 0; c < 3; c++) begin
      diff[c] = V_W'(lp2[c]) - V_W'(np2[c]);
      rnd[c]  = {diff[c][V_W-1], diff[c]} + (V_W+1)'(HALF) - (V_W+1)'(diff[c][V_W-1]);
      vq[c]   = rnd[c][V_W:FRAC_BITS];
      if (vq[c] > VMAX) begin
        res[c]  = 16'h7fff;
        sat_any = 1'b1;
      end else if (vq[c] < VMIN) begin
        res[c]  = 16'h8000;
        sat_any = 1'b1;
      end else begin
        res[c] = vq[c][15:0];
      end
    end
    // total internal reflection drops the vector and the clamp flag
    if (tir2) begin
      res     = '0;
      sat_any = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tq1  <= t_r[T_W:FRAC_BITS];
      li1  <= light;
      nv1  <= normal;
      tir1 <= tir;
    end
    if (en[1]) begin
      for (int c = 0; c < 3; c++) begin
        lp2[c] <= $signed({1'b0, ratio}) * $signed(li1[c]);
        np2[c] <= $signed(nv1[c]) * tq1;
      end
      tir2 <= tir1;
    end
    if (en[2]) begin
      out_vec <= res;
      out_tir <= tir2;
      out_sat <= sat_any;
    end
  end

endmodule

[design/vr_checker.sv]
// Port-level checks for vector_refraction, attached by the bind below.
// Depends on vr_pkg and on the vector_refraction port list.
module vr_checker
  import vr_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [47:0]           m_tdata,
  input logic [1:0]            m_tuser
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // total internal reflection gives the zero vector and no clamp flag
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 48'd0 && !m_tuser[1])
    else $error("tir word carries data or clamp flag");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // the ratio reads back what was written
  a_cfg_back: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && !paddr[2]
    |=> paddr[2] || prdata == {16'd0, $past(pwdata[15:0])})
    else $error("ratio readback mismatch");

endmodule

bind vector_refraction vr_checker u_checker (.*);

[dv/vector_refraction_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for vector_refraction: streams light/normal word pairs at fixed and random
// ratios and stall patterns, compares every output word with a fixed-point predictor or with a
// directed row's expected value. Depends on vr_pkg and the vector_refraction RTL.
module vector_refraction_test;
  import vr_pkg::*;

  localparam int FRAC = 14;
  localparam longint ONE2 = longint'(1) << (2 * FRAC);
  localparam longint unsigned P_LIMIT = 64'd1 << 62;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS = 175;
  localparam int NUM_PHASES = 8;
  localparam logic [CFG_ADDR_W-3:0] REG_UNMAPPED = 1'b1;

  typedef struct {
    vec3_t v;
    logic  tir;
    logic  sat;
  } refract_t;

  typedef struct {
    logic [15:0] ratio;
    vec3_t       light;
    vec3_t       normal;
    bit          checked;
    refract_t    want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  // light_x, light_y, light_z, normal_x, normal_y, normal_z
  logic [95:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // out_x, out_y, out_z
  logic [47:0]           m_tdata;
  // total_internal, saturated
  logic [1:0]            m_tuser;

  refract_t    pending_refractions[$];
  logic [15:0] ratio_now;
  int          mismatch_count = 0;
  int          stalled_cycles = 0;
  int          tx_gap_pct;
  int          rx_stall_pct;
  int          rx_hold = 0;

  vector_refraction #(.FRAC_BITS(FRAC)) uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round to nearest, ties away from zero
  function automatic longint rnd_shift(input longint x, input int sh);
    longint unsigned mag;
    mag = (x < 0) ? -x : x;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic refract_t refract_predict(input vec3_t light, input vec3_t normal,
                                               input logic [15:0] eta_q);
    longint li[3];
    longint nv[3];
    longint eta, dot, dq, omd, e2, p, k, t, tq, v;
    longint unsigned pa, pb, pm, root, cand;
    refract_t r;
    eta = eta_q;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      li[i] = $signed(light[i]);
      nv[i] = $signed(normal[i]);
      dot += li[i] * nv[i];
    end
    dq  = rnd_shift(dot, FRAC);
    omd = rnd_shift(ONE2 - dq * dq, FRAC);
    e2  = rnd_shift(eta * eta, FRAC);
    // clamp the magnitude of eta^2 * (1 - d^2) at 2^62
    pa = (e2 < 0) ? -e2 : e2;
    pb = (omd < 0) ? -omd : omd;
    if (pa != 0 && pb > P_LIMIT / pa) pm = P_LIMIT;
    else pm = pa * pb;
    if (pm > P_LIMIT) pm = P_LIMIT;
    p = ((e2 < 0) != (omd < 0)) ? -longint'(pm) : longint'(pm);
    k = ONE2 - p;
    r.v   = '0;
    r.tir = 1'b0;
    r.sat = 1'b0;
    if (k < 0) begin
      r.tir = 1'b1;
      return r;
    end
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= longint'(k)) root = cand;
    end
    t  = eta * dq + longint'(root << FRAC);
    tq = rnd_shift(t, FRAC);
    for (int i = 0; i < 3; i++) begin
      v = rnd_shift(eta * li[i] - nv[i] * tq, FRAC);
      if (v > 32767) begin
        v = 32767;
        r.sat = 1'b1;
      end else if (v < -32768) begin
        v = -32768;
        r.sat = 1'b1;
      end
      r.v[i] = 16'(v);
    end
    return r;
  endfunction

  function automatic stim_row_t row(input logic [15:0] ratio,
                                    input int lx, input int ly, input int lz,
                                    input int nx, input int ny, input int nz,
                                    input bit checked = 1'b0,
                                    input int ox = 0, input int oy = 0, input int oz = 0,
                                    input bit tir = 1'b0, input bit sat = 1'b0);
    stim_row_t r;
    r.ratio    = ratio;
    r.light    = {16'(lz), 16'(ly), 16'(lx)};
    r.normal   = {16'(nz), 16'(ny), 16'(nx)};
    r.checked  = checked;
    r.want.v   = {16'(oz), 16'(oy), 16'(ox)};
    r.want.tir = tir;
    r.want.sat = sat;
    return r;
  endfunction

  // mix of full-range noise, near-unit vectors, mid-range values, extremes and tiny values
  function automatic vec3_t rand_vec();
    vec3_t v;
    int pick, axis, c;
    pick = $urandom_range(99);
    axis = $urandom_range(2);
    for (int i = 0; i < 3; i++) begin
      if (pick < 20) begin
        c = int'($urandom_range(65535)) - 32768;
      end else if (pick < 50) begin
        if (i == axis) c = 16384 - int'($urandom_range(1500));
        else c = int'($urandom_range(4000)) - 2000;
        if ($urandom_range(1) == 1) c = -c;
      end else if (pick < 80) begin
        c = int'($urandom_range(18918)) - 9459;
      end else if (pick < 90) begin
        case ($urandom_range(6))
          0: c = -32768;
          1: c = -16384;
          2: c = -1;
          3: c = 0;
          4: c = 1;
          5: c = 16384;
          default: c = 32767;
        endcase
      end else begin
        c = int'($urandom_range(128)) - 64;
      end
      v[i] = 16'(c);
    end
    return v;
  endfunction

  task automatic send_word(input stim_row_t r);
    int gap;
    if ($urandom_range(99) < tx_gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {r.normal, r.light};
    do @(posedge clk); while (!s_tready);
    pending_refractions.push_back(r.checked ? r.want
                                            : refract_predict(r.light, r.normal, ratio_now));
  endtask

  // hold the sender until every expected word has come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_refractions.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [CFG_ADDR_W-3:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_ratio(input logic [31:0] value);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, REG_RATIO, value, rd);
    ratio_now = value[15:0];
    apb_access(1'b0, REG_RATIO, 32'h0, rd);
    if (rd[15:0] !== ratio_now) begin
      $error("refraction_ratio readback: expected %0d, got %0d", ratio_now, rd[15:0]);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls, mostly short, a few long
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else if (int'($urandom_range(99)) < rx_stall_pct) begin
        rx_hold  = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(3, 1);
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    refract_t want;
    string    comp_name[3];
    comp_name = '{"out_x", "out_y", "out_z"};
    if (!rst && m_tvalid && m_tready) begin
      if (pending_refractions.size() == 0) begin
        $error("output word with no expectation pending");
        mismatch_count++;
      end else begin
        want = pending_refractions.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (m_tdata[16*i +: 16] !== want.v[i]) begin
            $error("%s: expected %0d, got %0d", comp_name[i], $signed(want.v[i]),
                   $signed(m_tdata[16*i +: 16]));
            mismatch_count++;
          end
        end
        if (m_tuser[0] !== want.tir) begin
          $error("total_internal: expected %0b, got %0b", want.tir, m_tuser[0]);
          mismatch_count++;
        end
        if (m_tuser[1] !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, m_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    stim_row_t   directed[$];
    stim_row_t   r;
    logic [31:0] rd;
    logic [31:0] phase_ratio[NUM_PHASES];
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    ratio_now    = 16'd16384;

    directed = '{
      // reset ratio 1.0
      row(16384, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0),
      row(16384, 32767, -32768, 1, 0, 0, 0, 1, 32767, -32768, 1),
      row(16384, 16384, 0, 0, -16384, 0, 0, 1, 16384, 0, 0),
      // dot product lands on a half: ties round away from zero
      row(16384, 1, 0, 0, 8192, 0, 0, 1, 1, 0, 0),
      row(16384, -1, 0, 0, 8192, 0, 0, 1, -1, 0, 0),
      row(16384, -32768, -32768, -32768, -32768, -32768, -32768),
      row(16384, 32767, 32767, 32767, 32767, 32767, 32767),
      row(16384, 0, -16384, 0, 0, 16384, 0),
      row(16384, 11585, -11585, 0, 0, 16384, 0),
      row(16384, -1, 1, -1, 1, -1, 1),
      row(16384, 12345, -2345, 7000, -300, 16000, -900),
      // ratio 0: output is -N, clamped
      row(0, 5, 6, 7, -32768, 0, 32767, 1, 32767, 0, -32767, 0, 1),
      row(0, 32767, -32768, 100, 16384, -16384, 0),
      // ratio at its maximum
      row(65535, 16384, 0, 0, 0, 16384, 0, 1, 0, 0, 0, 1, 0),
      row(65535, 32767, 32767, 32767, 32767, 32767, 32767),
      row(65535, -32768, -32768, -32768, -32768, -32768, -32768),
      row(65535, 16384, 0, 0, -16384, 0, 0),
      row(65535, 0, 0, 0, 0, 0, 0),
      // ratio 2.0: total internal reflection at grazing angles
      row(32768, 16384, 0, 0, 0, 16384, 0, 1, 0, 0, 0, 1, 0),
      row(32768, 0, -16384, 0, 0, 16384, 0),
      row(32768, 16000, -3000, 0, 0, 16384, 0),
      row(32768, -32768, 32767, -32768, 32767, -32768, 32767)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].ratio !== ratio_now) set_ratio({16'h0000, directed[i].ratio});
      send_word(directed[i]);
    end

    // write to an unmapped index must leave the ratio alone
    drain();
    apb_access(1'b1, REG_UNMAPPED, 32'h0000_2345, rd);
    apb_access(1'b0, REG_RATIO, 32'h0, rd);
    if (rd[15:0] !== ratio_now) begin
      $error("refraction_ratio after unmapped write: expected %0d, got %0d",
             ratio_now, rd[15:0]);
      mismatch_count++;
    end

    phase_ratio = '{32'h0000_3000, 32'h0000_5555, 32'h0000_0000, 32'h0000_FFFF,
                    32'h0000_6000, 32'hFFFF_4000, 32'h0000_1000, 32'h0};
    phase_ratio[NUM_PHASES-1] = {16'($urandom), 16'($urandom)};

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        2: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
        5: begin
          tx_gap_pct   = 60;
          rx_stall_pct = 60;
        end
        default: begin
          tx_gap_pct   = 25;
          rx_stall_pct = 25;
        end
      endcase
      set_ratio(phase_ratio[ph]);
      repeat (PHASE_WORDS) begin
        r.ratio   = ratio_now;
        r.light   = rand_vec();
        r.normal  = rand_vec();
        r.checked = 1'b0;
        send_word(r);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

[vector_refraction.f]
design/vr_pkg.sv
design/vr_cfg.sv
design/vr_front.sv
design/vr_sqrt.sv
design/vr_back.sv
design/vector_refraction.sv
design/vr_checker.sv
dv/vector_refraction_test.sv
